// File: design/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// Types and constants shared by the JSON string unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

    localparam logic [1:0] MODE_NORMAL  = 2'd0;
    localparam logic [1:0] MODE_ESCAPE  = 2'd1;
    localparam logic [1:0] MODE_UNICODE = 2'd2;

    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_B         = 8'h62;
    localparam logic [7:0] CH_F         = 8'h66;
    localparam logic [7:0] CH_N         = 8'h6E;
    localparam logic [7:0] CH_R         = 8'h72;
    localparam logic [7:0] CH_T         = 8'h74;
    localparam logic [7:0] CH_U         = 8'h75;

    localparam logic [7:0] CTRL_BS = 8'h08;
    localparam logic [7:0] CTRL_FF = 8'h0C;
    localparam logic [7:0] CTRL_LF = 8'h0A;
    localparam logic [7:0] CTRL_CR = 8'h0D;
    localparam logic [7:0] CTRL_HT = 8'h09;

    localparam int MAX_RESULTS = 3;
    localparam logic [2:0] HEX_CHARS = 3'd4;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       is_last;
    } text_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       run_last;
        logic       text_end;
        logic       bad_escape;
    } char_item_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [2:0]  hex_count;
        logic [15:0] hex_value;
        logic        run_open;
    } parse_state_t;

    localparam parse_state_t STATE_RESET = '{
        mode: MODE_NORMAL, hex_count: 3'd0, hex_value: 16'd0, run_open: 1'b1
    };

endpackage

// File: design/jsu_decode.sv
// ----------------------------------------------------------------------------
// jsu_decode
// Decodes one escaped byte against the parse state into up to three
// result bytes and the next parse state.
// ----------------------------------------------------------------------------
module jsu_decode (
    input  jsu_pkg::text_item_t   item,
    input  jsu_pkg::parse_state_t state,
    output jsu_pkg::parse_state_t state_next,
    output jsu_pkg::char_item_t   results [jsu_pkg::MAX_RESULTS],
    output logic [1:0]            count
);

    logic [7:0]  bytes [jsu_pkg::MAX_RESULTS];
    logic [1:0]  n;
    logic        bad;
    logic        is_hex;
    logic [3:0]  digit;
    logic [15:0] value;
    logic [2:0]  cnt;
    logic [7:0]  ch;

    assign ch = item.in_byte;

    always_comb
    begin
        is_hex = 1'b1;
        digit  = 4'd0;
        if (ch inside {[8'h30:8'h39]})
        begin
            digit = ch[3:0];
        end
        else if (ch inside {[8'h61:8'h66], [8'h41:8'h46]})
        begin
            digit = ch[3:0] + 4'd9;
        end
        else
        begin
            is_hex = 1'b0;
        end
    end

    always_comb
    begin
        state_next = state;
        n          = 2'd0;
        bad        = 1'b0;
        bytes[0]   = ch;
        bytes[1]   = 8'd0;
        bytes[2]   = 8'd0;
        value      = (state.run_open && is_hex) ? {state.hex_value[11:0], digit}
                                                : state.hex_value;
        cnt        = state.hex_count + 3'd1;

        case (state.mode)
            jsu_pkg::MODE_ESCAPE:
            begin
                state_next.mode = jsu_pkg::MODE_NORMAL;
                if (ch == jsu_pkg::CH_U)
                begin
                    state_next = jsu_pkg::STATE_RESET;
                    state_next.mode = jsu_pkg::MODE_UNICODE;
                    bad = item.is_last;
                end
                else
                begin
                    n = 2'd1;
                    case (ch)
                        jsu_pkg::CH_B: bytes[0] = jsu_pkg::CTRL_BS;
                        jsu_pkg::CH_F: bytes[0] = jsu_pkg::CTRL_FF;
                        jsu_pkg::CH_N: bytes[0] = jsu_pkg::CTRL_LF;
                        jsu_pkg::CH_R: bytes[0] = jsu_pkg::CTRL_CR;
                        jsu_pkg::CH_T: bytes[0] = jsu_pkg::CTRL_HT;
                        default:       bytes[0] = ch;
                    endcase
                end
            end
            jsu_pkg::MODE_UNICODE:
            begin
                state_next.hex_value = value;
                state_next.run_open  = state.run_open && is_hex;
                state_next.hex_count = cnt;
                if (cnt >= jsu_pkg::HEX_CHARS)
                begin
                    state_next = jsu_pkg::STATE_RESET;
                    if (value < 16'h0080)
                    begin
                        n        = 2'd1;
                        bytes[0] = value[7:0];
                    end
                    else if (value < 16'h0800)
                    begin
                        n        = 2'd2;
                        bytes[0] = {3'b110, value[10:6]};
                        bytes[1] = {2'b10, value[5:0]};
                    end
                    else
                    begin
                        n        = 2'd3;
                        bytes[0] = {4'b1110, value[15:12]};
                        bytes[1] = {2'b10, value[11:6]};
                        bytes[2] = {2'b10, value[5:0]};
                    end
                end
                else
                begin
                    bad = item.is_last;
                end
            end
            default:
            begin
                state_next.mode = jsu_pkg::MODE_NORMAL;
                if (ch == jsu_pkg::CH_BACKSLASH)
                begin
                    state_next.mode = jsu_pkg::MODE_ESCAPE;
                end
                else
                begin
                    n = 2'd1;
                end
            end
        endcase

        if (item.is_last)
        begin
            state_next = jsu_pkg::STATE_RESET;
        end
    end

    always_comb
    begin
        count = (n == 2'd0 && item.is_last) ? 2'd1 : n;
        for (int i = 0; i < jsu_pkg::MAX_RESULTS; i++)
        begin
            results[i].out_byte   = (n == 2'd0) ? 8'd0 : bytes[i];
            results[i].byte_valid = (n != 2'd0);
            results[i].run_last   = (count == 2'(i + 1));
            results[i].text_end   = (count == 2'(i + 1)) && item.is_last;
            results[i].bad_escape = (count == 2'(i + 1)) && item.is_last && bad;
        end
    end

endmodule

// File: design/json_string_unescaper.sv
// ----------------------------------------------------------------------------
// json_string_unescaper
// Streaming decoder for the body of a JSON string, with UTF-8 output.
// ----------------------------------------------------------------------------
// One escaped byte is taken per cycle while text_stall is low and decoded in
// the same cycle into a result buffer of three entries, which drains one byte
// per cycle while char_stall is low. Plain bytes and simple escapes sustain
// one byte per cycle unless the output stalls; a unicode escape that expands
// to two or three UTF-8 bytes holds off the next request while the buffer
// drains. Bytes that yield no result (backslash, escape digits) are absorbed.
module json_string_unescaper (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                text_valid,
    output logic                text_stall,
    input  jsu_pkg::text_item_t text_item,
    output logic                char_valid,
    input  logic                char_stall,
    output jsu_pkg::char_item_t char_item
);

    jsu_pkg::parse_state_t state_reg;
    jsu_pkg::parse_state_t state_next;
    jsu_pkg::char_item_t   results [jsu_pkg::MAX_RESULTS];
    jsu_pkg::char_item_t   buf_reg [jsu_pkg::MAX_RESULTS];
    logic [1:0]            count;
    logic [1:0]            cnt_reg;
    logic                  take;
    logic                  accept;

    jsu_decode u_decode (
        .item       (text_item),
        .state      (state_reg),
        .state_next (state_next),
        .results    (results),
        .count      (count)
    );

    assign char_valid = (cnt_reg != 2'd0);
    assign char_item  = buf_reg[0];
    assign take       = char_valid && !char_stall;
    assign text_stall = (cnt_reg > 2'd1) || (cnt_reg == 2'd1 && char_stall);
    assign accept     = text_valid && !text_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= jsu_pkg::STATE_RESET;
            cnt_reg   <= 2'd0;
        end
        else
        begin
            if (accept)
            begin
                state_reg <= state_next;
                cnt_reg   <= count;
            end
            else if (take)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            buf_reg <= results;
        end
        else if (take)
        begin
            buf_reg[0] <= buf_reg[1];
            buf_reg[1] <= buf_reg[2];
        end
    end

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the JSON string unescaper. Escaped text is fed
// byte by byte, with random gaps and random output stalls during the random
// texts; a behavioral decoder predicts every UTF-8 byte and end marker, and
// each output is compared field by field in arrival order.
// ----------------------------------------------------------------------------
module tb;

    localparam int          CYCLE_LIMIT   = 400000;
    localparam int          RANDOM_ITEMS  = 350;
    localparam int          STEADY_ITEMS  = 80;
    localparam int          DRAIN_CYCLES  = 20;
    localparam logic [7:0]  ASCII_ZERO    = 8'h30;
    localparam logic [7:0]  ASCII_UPPER_A = 8'h41;
    localparam logic [7:0]  ASCII_LOWER_A = 8'h61;

    logic                 clk        = 1'b0;
    logic                 rst_n      = 1'b0;
    logic                 text_valid = 1'b0;
    logic                 text_stall;
    jsu_pkg::text_item_t  text_item  = '0;
    logic                 char_valid;
    logic                 char_stall = 1'b0;
    jsu_pkg::char_item_t  char_item;

    jsu_pkg::parse_state_t decoder_state = jsu_pkg::STATE_RESET;
    jsu_pkg::char_item_t   char_expect_q[$];
    logic [7:0]            text_bytes[$];
    int                    err_count   = 0;
    int                    items_sent  = 0;
    int                    cycle_count = 0;
    int                    stall_left  = 0;
    logic                  rx_idle_on  = 1'b0;
    logic                  tx_idle_on  = 1'b0;

    json_string_unescaper u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_valid (text_valid),
        .text_stall (text_stall),
        .text_item  (text_item),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_item  (char_item)
    );

    always #4 clk = ~clk;

    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic int hex_nibble(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return c - 8'h30;
        if (c >= 8'h61 && c <= 8'h66) return c - 8'h61 + 10;
        if (c >= 8'h41 && c <= 8'h46) return c - 8'h41 + 10;
        return -1;
    endfunction

    function automatic jsu_pkg::char_item_t byte_result(input logic [7:0] b);
        jsu_pkg::char_item_t r;
        r = '0;
        r.out_byte   = b;
        r.byte_valid = 1'b1;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("tb: mismatch on %s at cycle %0d: got %02h, want %02h",
                 what, cycle_count, got, want);
        err_count++;
    endtask

    // predicted decode of one accepted request
    task automatic decode_request(input jsu_pkg::text_item_t req);
        jsu_pkg::char_item_t outs[$];
        logic [7:0]  ch;
        logic [7:0]  b;
        logic [15:0] cp;
        logic        bad;
        int          d;
        int          n;
        ch  = req.in_byte;
        bad = 1'b0;
        case (decoder_state.mode)
            jsu_pkg::MODE_ESCAPE:
            begin
                decoder_state.mode = jsu_pkg::MODE_NORMAL;
                if (ch == jsu_pkg::CH_U)
                begin
                    decoder_state.mode      = jsu_pkg::MODE_UNICODE;
                    decoder_state.hex_count = '0;
                    decoder_state.hex_value = '0;
                    decoder_state.run_open  = 1'b1;
                    if (req.is_last) bad = 1'b1;
                end
                else
                begin
                    case (ch)
                        jsu_pkg::CH_B: b = jsu_pkg::CTRL_BS;
                        jsu_pkg::CH_F: b = jsu_pkg::CTRL_FF;
                        jsu_pkg::CH_N: b = jsu_pkg::CTRL_LF;
                        jsu_pkg::CH_R: b = jsu_pkg::CTRL_CR;
                        jsu_pkg::CH_T: b = jsu_pkg::CTRL_HT;
                        default:       b = ch;
                    endcase
                    outs.push_back(byte_result(b));
                end
            end
            jsu_pkg::MODE_UNICODE:
            begin
                d = hex_nibble(ch);
                if (decoder_state.run_open && d >= 0)
                    decoder_state.hex_value = {decoder_state.hex_value[11:0], d[3:0]};
                else
                    decoder_state.run_open = 1'b0;
                decoder_state.hex_count = decoder_state.hex_count + 3'd1;
                if (decoder_state.hex_count >= jsu_pkg::HEX_CHARS)
                begin
                    cp = decoder_state.hex_value;
                    if (cp < 16'h0080)
                        outs.push_back(byte_result(cp[7:0]));
                    else if (cp < 16'h0800)
                    begin
                        outs.push_back(byte_result({3'b110, cp[10:6]}));
                        outs.push_back(byte_result({2'b10, cp[5:0]}));
                    end
                    else
                    begin
                        outs.push_back(byte_result({4'b1110, cp[15:12]}));
                        outs.push_back(byte_result({2'b10, cp[11:6]}));
                        outs.push_back(byte_result({2'b10, cp[5:0]}));
                    end
                    decoder_state = jsu_pkg::STATE_RESET;
                end
                else if (req.is_last)
                    bad = 1'b1;
            end
            default:
            begin
                if (ch == jsu_pkg::CH_BACKSLASH)
                    decoder_state.mode = jsu_pkg::MODE_ESCAPE;
                else
                    outs.push_back(byte_result(ch));
            end
        endcase
        if (req.is_last)
        begin
            if (outs.size() == 0)
                outs.push_back('0);
            n = outs.size() - 1;
            outs[n].text_end   = 1'b1;
            outs[n].bad_escape = bad;
            decoder_state = jsu_pkg::STATE_RESET;
        end
        n = outs.size();
        if (n > 0)
            outs[n - 1].run_last = 1'b1;
        foreach (outs[i])
            char_expect_q.push_back(outs[i]);
    endtask

    task automatic check_char(input jsu_pkg::char_item_t got);
        jsu_pkg::char_item_t want;
        if (char_expect_q.size() == 0)
        begin
            report_mismatch("result with none expected", got.out_byte, 8'h00);
            return;
        end
        want = char_expect_q.pop_front();
        if (got.out_byte !== want.out_byte)
            report_mismatch("out_byte", got.out_byte, want.out_byte);
        if (got.byte_valid !== want.byte_valid)
            report_mismatch("byte_valid", 8'(got.byte_valid), 8'(want.byte_valid));
        if (got.run_last !== want.run_last)
            report_mismatch("run_last", 8'(got.run_last), 8'(want.run_last));
        if (got.text_end !== want.text_end)
            report_mismatch("text_end", 8'(got.text_end), 8'(want.text_end));
        if (got.bad_escape !== want.bad_escape)
            report_mismatch("bad_escape", 8'(got.bad_escape), 8'(want.bad_escape));
    endtask

    // predict on accepted requests, then check accepted results
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (text_valid && !text_stall)
                decode_request(text_item);
            if (char_valid && !char_stall)
                check_char(char_item);
        end
    end

    // output side back-pressure
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            char_stall <= 1'b1;
        end
        else if (rx_idle_on && $urandom_range(0, 3) == 0)
        begin
            stall_left <= pick_gap() - 1;
            char_stall <= 1'b1;
        end
        else
            char_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: done, errors");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = 0;
        if (tx_idle_on && $urandom_range(0, 3) == 0)
            gap = pick_gap();
        if (gap > 0)
        begin
            text_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        text_valid <= 1'b1;
        text_item  <= '{in_byte: b, is_last: last};
        do @(posedge clk); while (text_stall);
        items_sent++;
    endtask

    task automatic send_str(input string s, input logic end_text);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], end_text && (i == s.len() - 1));
    endtask

    task automatic send_text_bytes();
        foreach (text_bytes[i])
            send_byte(text_bytes[i], i == text_bytes.size() - 1);
    endtask

    task automatic wait_for_drain();
        text_valid <= 1'b0;
        do @(posedge clk); while (char_expect_q.size() != 0);
    endtask

    function automatic logic [7:0] pick_escape_char();
        case ($urandom_range(0, 9))
            0:       return jsu_pkg::CH_B;
            1:       return jsu_pkg::CH_F;
            2:       return jsu_pkg::CH_N;
            3:       return jsu_pkg::CH_R;
            4:       return jsu_pkg::CH_T;
            5:       return jsu_pkg::CH_BACKSLASH;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] pick_hex_char();
        int nib;
        if ($urandom_range(0, 9) == 0)
            return 8'($urandom_range(0, 255));
        nib = $urandom_range(0, 15);
        if (nib < 10)
            return 8'(ASCII_ZERO + nib);
        if ($urandom_range(0, 1) == 0)
            return 8'(ASCII_UPPER_A + nib - 10);
        return 8'(ASCII_LOWER_A + nib - 10);
    endfunction

    task automatic build_random_text();
        int kind;
        text_bytes.delete();
        repeat ($urandom_range(1, 8))
        begin
            kind = $urandom_range(0, 99);
            if (kind < 50)
                text_bytes.push_back(8'($urandom_range(0, 255)));
            else if (kind < 70)
            begin
                text_bytes.push_back(jsu_pkg::CH_BACKSLASH);
                text_bytes.push_back(pick_escape_char());
            end
            else
            begin
                text_bytes.push_back(jsu_pkg::CH_BACKSLASH);
                text_bytes.push_back(jsu_pkg::CH_U);
                repeat (4) text_bytes.push_back(pick_hex_char());
            end
        end
        // cut some texts short, often inside an escape
        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(0, text_bytes.size() - 1)) void'(text_bytes.pop_back());
    endtask

    task automatic test_plain_bytes();
        send_byte(8'h00, 1'b0);
        send_byte(jsu_pkg::CH_BACKSLASH, 1'b0);
        send_byte(8'hFF, 1'b1);
    endtask

    task automatic test_simple_escapes();
        send_str("\\b\\f\\n\\r\\t", 1'b1);
    endtask

    task automatic test_unicode_escapes();
        // surrogate, two-byte with a non-hex tail, one-byte cut by a non-hex
        send_str("\\uDFFF\\u7FFz\\u4g00", 1'b1);
    endtask

    task automatic test_text_endings();
        send_str("\\", 1'b1);
        send_str("\\u", 1'b1);
        send_str("\\u0", 1'b1);
    endtask

    task automatic test_random_texts();
        int first;
        int texts;
        first = items_sent;
        texts = 0;
        tx_idle_on = 1'b1;
        rx_idle_on <= 1'b1;
        while (items_sent - first < RANDOM_ITEMS)
        begin
            build_random_text();
            send_text_bytes();
            texts++;
            if (texts % 25 == 0)
                wait_for_drain();
        end
    endtask

    task automatic test_back_to_back();
        int first;
        first = items_sent;
        tx_idle_on = 1'b0;
        rx_idle_on <= 1'b0;
        while (items_sent - first < STEADY_ITEMS)
        begin
            build_random_text();
            send_text_bytes();
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_plain_bytes();
        test_simple_escapes();
        test_unicode_escapes();
        test_text_endings();
        test_random_texts();
        test_back_to_back();
        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
